// ===== rtl/slmfb_pkg.sv =====
`timescale 1ns / 1ps
package slmfb_pkg;

  // Matrix geometry
  localparam int GRID_SIDE = 5;
  localparam int LED_COUNT = GRID_SIDE * GRID_SIDE;
  localparam int IDX_W     = $clog2(LED_COUNT);
  localparam int COORD_W   = $clog2(GRID_SIDE);

  // Command queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef logic [IDX_W-1:0] idx_t;

  // Request kinds as they arrive on the input channel
  typedef enum logic [1:0] {
    REQ_WRITE_XY   = 2'd0,
    REQ_FILL       = 2'd1,
    REQ_WRITE_ZERO = 2'd2,
    REQ_SHOW       = 2'd3
  } req_kind_t;

  // Operations carried out by the back end
  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_FILL  = 2'd1,
    CMD_SHOW  = 2'd2
  } cmd_op_t;

  typedef struct packed {
    req_kind_t          req_type;
    logic signed [7:0]  col_x;
    logic signed [7:0]  row_y;
    logic [7:0]         red_level;
    logic [7:0]         green_level;
    logic [7:0]         blue_level;
    logic [23:0]        packed_colour;
  } req_t;

  typedef struct packed {
    logic [4:0] led_position;
    logic [7:0] out_green;
    logic [7:0] out_red;
    logic [7:0] out_blue;
    logic       last_led;
  } res_t;

  // Classified command: colour is GRB packed, green in 23:16
  typedef struct packed {
    cmd_op_t     op;
    idx_t        addr;
    logic [23:0] colour;
  } cmd_t;

endpackage

// ===== rtl/slmfb_req_if.sv =====
`timescale 1ns / 1ps
interface slmfb_req_if import slmfb_pkg::*;;
  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/slmfb_res_if.sv =====
`timescale 1ns / 1ps
interface slmfb_res_if import slmfb_pkg::*;;
  logic valid;
  logic ready;
  res_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/slmfb_cmd_if.sv =====
`timescale 1ns / 1ps
interface slmfb_cmd_if import slmfb_pkg::*;;
  logic valid;
  logic ready;
  cmd_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/slmfb_front.sv =====
`timescale 1ns / 1ps
module slmfb_front import slmfb_pkg::*; (
  slmfb_req_if.sink   req,
  slmfb_cmd_if.source cmd
);

  // Clamp a signed coordinate into 0..GRID_SIDE-1
  function automatic logic [COORD_W-1:0] sat_coord(input logic signed [7:0] v);
    if (v < 0) begin
      return '0;
    end else if (v > $signed(8'(GRID_SIDE - 1))) begin
      return COORD_W'(GRID_SIDE - 1);
    end else begin
      return v[COORD_W-1:0];
    end
  endfunction

  logic [COORD_W-1:0] x_sat;
  logic [COORD_W-1:0] y_sat;
  logic [COORD_W-1:0] col;
  idx_t               xy_idx;
  logic [23:0]        grb;

  // Map (x,y) to chain order: even rows run mirrored
  always_comb begin
    x_sat  = sat_coord(req.data.col_x);
    y_sat  = sat_coord(req.data.row_y);
    col    = y_sat[0] ? x_sat : (COORD_W'(GRID_SIDE - 1) - x_sat);
    xy_idx = IDX_W'(y_sat) * IDX_W'(GRID_SIDE) + IDX_W'(col);
    grb    = {req.data.green_level, req.data.red_level, req.data.blue_level};
  end

  // Classify the request into a back-end command
  always_comb begin
    cmd.data.op     = CMD_SHOW;
    cmd.data.addr   = '0;
    cmd.data.colour = grb;
    case (req.data.req_type)
      REQ_WRITE_XY: begin
        cmd.data.op   = CMD_WRITE;
        cmd.data.addr = xy_idx;
      end
      REQ_FILL: begin
        cmd.data.op = CMD_FILL;
      end
      REQ_WRITE_ZERO: begin
        cmd.data.op     = CMD_WRITE;
        cmd.data.colour = req.data.packed_colour;
      end
      REQ_SHOW: begin
        cmd.data.op = CMD_SHOW;
      end
      default: begin
        cmd.data.op = CMD_SHOW;
      end
    endcase
  end

  assign cmd.valid = req.valid;
  assign req.ready = cmd.ready;

endmodule

// ===== rtl/slmfb_queue.sv =====
`timescale 1ns / 1ps
module slmfb_queue import slmfb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  slmfb_cmd_if.sink   in_c,
  slmfb_cmd_if.source out_c
);

  cmd_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic              pop;

  assign in_c.ready  = (count != QCNT_W'(QDEPTH));
  assign out_c.valid = (count != '0);
  assign out_c.data  = slots[rd_ptr];
  assign push        = in_c.valid && in_c.ready;
  assign pop         = out_c.valid && out_c.ready;

  // Store pushed commands
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_c.data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/slmfb_back.sv =====
`timescale 1ns / 1ps
module slmfb_back import slmfb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  slmfb_cmd_if.sink   cmd,
  slmfb_res_if.source res
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_FILL = 3'b010,
    ST_SHOW = 3'b100
  } state_t;

  localparam idx_t LAST_IDX = IDX_W'(LED_COUNT - 1);

  state_t      state;
  state_t      state_next;
  idx_t        cnt;
  idx_t        cnt_next;
  logic [23:0] fill_colour;

  logic [23:0]          mem [LED_COUNT];
  logic [LED_COUNT-1:0] vld;
  logic                 we;
  idx_t                 waddr;
  logic [23:0]          wdata;

  logic        inflight;
  logic [23:0] rd_data;
  logic        rd_hit;
  idx_t        rd_pos;
  res_t        land;

  logic        out_v;
  res_t        out_data;
  logic        skid_v;
  res_t        skid_data;
  logic [1:0]  occ;
  logic        pop;
  logic        issue;

  assign cmd.ready = (state == ST_IDLE);
  assign pop       = out_v && res.ready;
  assign occ       = {1'b0, inflight} + {1'b0, out_v} + {1'b0, skid_v};

  // Issue a read only when the output stages can absorb it
  assign issue = (state == ST_SHOW) && ((occ < 2'd2) || (pop && occ == 2'd2));

  // Select the store write
  always_comb begin
    we    = 1'b0;
    waddr = cmd.data.addr;
    wdata = cmd.data.colour;
    if (state == ST_IDLE && cmd.valid && cmd.data.op == CMD_WRITE) begin
      we = 1'b1;
    end else if (state == ST_FILL) begin
      we    = 1'b1;
      waddr = cnt;
      wdata = fill_colour;
    end
  end

  // Sequence fill and show sweeps
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    case (state)
      ST_IDLE: begin
        cnt_next = '0;
        if (cmd.valid) begin
          case (cmd.data.op)
            CMD_FILL: state_next = ST_FILL;
            CMD_SHOW: state_next = ST_SHOW;
            default:  state_next = ST_IDLE;
          endcase
        end
      end
      ST_FILL: begin
        cnt_next = cnt + 1'b1;
        if (cnt == LAST_IDX) begin
          state_next = ST_IDLE;
          cnt_next   = '0;
        end
      end
      ST_SHOW: begin
        if (issue) begin
          cnt_next = cnt + 1'b1;
          if (cnt == LAST_IDX) begin
            state_next = ST_IDLE;
            cnt_next   = '0;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
        cnt_next   = '0;
      end
    endcase
  end

  // Frame store with registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (issue) begin
      rd_data <= mem[cnt];
      rd_hit  <= vld[cnt];
      rd_pos  <= cnt;
    end
  end

  // Latch the fill colour
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && cmd.valid && cmd.data.op == CMD_FILL) begin
      fill_colour <= cmd.data.colour;
    end
  end

  // Build the result from the read; unwritten entries read as zero
  always_comb begin
    land.led_position = 5'(rd_pos);
    land.out_green    = rd_hit ? rd_data[23:16] : 8'h00;
    land.out_red      = rd_hit ? rd_data[15:8] : 8'h00;
    land.out_blue     = rd_hit ? rd_data[7:0] : 8'h00;
    land.last_led     = (rd_pos == LAST_IDX);
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cnt      <= '0;
      vld      <= '0;
      inflight <= 1'b0;
      out_v    <= 1'b0;
      skid_v   <= 1'b0;
    end else begin
      state    <= state_next;
      cnt      <= cnt_next;
      inflight <= issue;
      if (we) begin
        vld[waddr] <= 1'b1;
      end
      if (pop || !out_v) begin
        if (skid_v) begin
          out_v  <= 1'b1;
          skid_v <= inflight;
        end else begin
          out_v <= inflight;
        end
      end else if (inflight) begin
        skid_v <= 1'b1;
      end
    end
  end

  // Output register and skid payload
  always_ff @(posedge clk) begin
    if (pop || !out_v) begin
      if (skid_v) begin
        out_data <= skid_data;
        if (inflight) begin
          skid_data <= land;
        end
      end else if (inflight) begin
        out_data <= land;
      end
    end else if (inflight) begin
      skid_data <= land;
    end
  end

  assign res.valid = out_v;
  assign res.data  = out_data;

endmodule

// ===== rtl/serpentine_led_matrix_frame_buffer.sv =====
`timescale 1ns / 1ps
// Channel  Dir  Handshake      Carries
// req      in   valid/ready    request kind, x, y, red, green, blue, packed colour
// res      out  valid/ready    chain position, green, red, blue, last-LED mark
//
// Pixel and entry-zero writes go into the store as the back end takes them. Fill and show each
// hold the back end: the cycle that takes the command, then one store entry per cycle,
// written for a fill and read for a show. A stalled res stretches a show.
// Show emits one LED per cycle while res is ready; an output register and a
// skid slot let the store read run ahead by one. Reset clears the per-entry
// valid bits at once, so no clearing sweep follows. A two-deep command queue
// lets requests be taken while the back end is busy or res is stalled.
module serpentine_led_matrix_frame_buffer import slmfb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  slmfb_req_if.sink   req,
  slmfb_res_if.source res
);

  slmfb_cmd_if cmd_in ();
  slmfb_cmd_if cmd_out ();

  slmfb_front u_front (
    .req (req),
    .cmd (cmd_in)
  );

  slmfb_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .in_c  (cmd_in),
    .out_c (cmd_out)
  );

  slmfb_back u_back (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_out),
    .res (res)
  );

`ifndef SYNTHESIS
  // Queued command holds while the back end is busy
  a_cmd_hold: assert property (@(posedge clk) disable iff (rst)
    cmd_out.valid && !cmd_out.ready |=> cmd_out.valid && $stable(cmd_out.data))
    else $error("queued command changed while stalled");

  // Leaving reset: queue open, no result pending
  a_reset_clean: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> (req.ready && !res.valid))
    else $error("block not clean after reset");

  // Last mark only on the final chain position
  a_last_pos: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.data.last_led |-> res.data.led_position == 5'(LED_COUNT - 1))
    else $error("last mark on wrong position");

  // A new frame starts at chain position zero
  a_frame_start: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.ready && res.data.last_led |=>
      !res.valid || res.data.led_position == 5'd0)
    else $error("frame did not restart at position zero");
`endif

endmodule
